// ===== design/dtwdm_pkg.sv =====
`default_nettype none
package dtwdm_pkg;

  localparam int MAX_LEN     = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_LEN);
  localparam int LEN_W       = 7;
  localparam int SUM_W       = 32;
  localparam int ROW_W       = 16;
  localparam int CMD_W       = 2;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LEN);
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [ROW_W-1:0] ROW_MAX   = {ROW_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_PROCESS = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef struct packed {
    op_e                           op;
    logic [IDX_W-1:0]              index;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

endpackage
`default_nettype wire

// ===== design/dtwdm_front.sv =====
`default_nettype none
module dtwdm_front
  import dtwdm_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [CMD_W-1:0]              command_i,
  input  wire logic [IDX_W-1:0]              template_index_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                               item_valid_o,
  output item_t                              item_o,
  input  wire logic                          item_ready_i
);

  item_t             fifo_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  item_t             cls;
  logic              keep;
  logic              push, pop;

  // classify: unknown command is accepted and dropped
  always_comb begin
    cls.index  = template_index_i;
    cls.sample = sample_i;
    cls.op     = OP_LOAD;
    keep       = 1'b1;
    unique case (command_i)
      CMD_LOAD:    cls.op = OP_LOAD;
      CMD_PROCESS: cls.op = OP_PROCESS;
      CMD_RESTART: cls.op = OP_RESTART;
      default:     keep   = 1'b0;
    endcase
  end

  assign in_ready_o   = (cnt_q != QCNT_W'(QDEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o && keep;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== design/dtwdm_back.sv =====
`default_nettype none
module dtwdm_back
  import dtwdm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_data_i,
  input  wire logic             item_valid_i,
  input  wire item_t            item_i,
  output logic                  item_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ROW_W-1:0]      row_index_o,
  output logic [IDX_W-1:0]      col_index_o,
  output logic [SUM_W-1:0]      distance_o,
  output logic                  last_in_row_o
);

  logic [SAMPLE_BITS-1:0] tmpl_mem [MAX_LEN];
  logic [SUM_W-1:0]       prev_mem [MAX_LEN];

  state_e                        state_q, state_d;
  logic [LEN_W-1:0]              len_q;
  logic [ROW_W-1:0]              row_cnt_q;
  logic [ROW_W-1:0]              row_idx_q;
  logic                          first_q;
  logic signed [SAMPLE_BITS-1:0] query_q;
  logic [IDX_W-1:0]              last_q, j_q;

  logic                   b_valid_q, b_last_q;
  logic [IDX_W-1:0]       b_col_q;
  logic [SAMPLE_BITS-1:0] t_q;
  logic [SUM_W-1:0]       up_q, diag_q;

  logic                   c_valid_q, c_last_q;
  logic [IDX_W-1:0]       c_col_q;
  logic [SAMPLE_BITS-1:0] c_cost_q;
  logic [SUM_W-1:0]       c_mu_q, left_q;

  logic                   out_valid_q;

  logic                   adv, pop, issue;
  logic [LEN_W-1:0]       len_m1;
  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS:0]   diff_abs;
  logic [SUM_W-1:0]       mu, base, cell_sum;
  logic [SUM_W:0]         sum;

  assign adv          = !out_valid_q || out_ready_i;
  assign item_ready_o = (state_q == ST_IDLE);
  assign pop          = item_valid_i && item_ready_o;
  assign issue        = (state_q == ST_RUN) && adv;
  assign out_valid_o  = out_valid_q;

  // clamp row length to 1..MAX_LEN
  always_comb begin
    if (len_q == '0) begin
      len_m1 = '0;
    end else if (len_q > LEN_W'(MAX_LEN)) begin
      len_m1 = LEN_W'(MAX_LEN - 1);
    end else begin
      len_m1 = len_q - 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop && item_i.op == OP_PROCESS) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (issue && j_q == last_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!b_valid_q && !c_valid_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // stage B: cost and min of diagonal / above
  always_comb begin
    diff     = $signed({query_q[SAMPLE_BITS-1], query_q})
             - $signed({t_q[SAMPLE_BITS-1], t_q});
    diff_abs = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : diff;
    if (b_col_q == '0) begin
      mu = up_q;
    end else begin
      mu = (diag_q < up_q) ? diag_q : up_q;
    end
  end

  // stage C: fold in left neighbor, saturating add
  always_comb begin
    if (c_col_q == '0) begin
      base = first_q ? '0 : c_mu_q;
    end else if (first_q) begin
      base = left_q;
    end else begin
      base = (left_q < c_mu_q) ? left_q : c_mu_q;
    end
    sum      = {1'b0, base} + (SUM_W+1)'(c_cost_q);
    cell_sum = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_RESET;
      row_cnt_q   <= '0;
      j_q         <= '0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      if (pop && item_i.op == OP_RESTART) begin
        row_cnt_q <= '0;
      end else if (pop && item_i.op == OP_PROCESS && row_cnt_q != ROW_MAX) begin
        row_cnt_q <= row_cnt_q + 1'b1;
      end
      if (pop) begin
        j_q <= '0;
      end else if (issue) begin
        j_q <= j_q + 1'b1;
      end
      if (adv) begin
        b_valid_q   <= issue;
        c_valid_q   <= b_valid_q;
        out_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      query_q   <= item_i.sample;
      last_q    <= len_m1[IDX_W-1:0];
      first_q   <= (row_cnt_q == '0);
      row_idx_q <= row_cnt_q;
    end
    if (adv) begin
      b_col_q  <= j_q;
      b_last_q <= (j_q == last_q);
      c_col_q  <= b_col_q;
      c_last_q <= b_last_q;
      c_cost_q <= diff_abs[SAMPLE_BITS-1:0];
      c_mu_q   <= mu;
      if (b_valid_q) begin
        diag_q <= up_q;
      end
      if (c_valid_q) begin
        left_q        <= cell_sum;
        row_index_o   <= row_idx_q;
        col_index_o   <= c_col_q;
        distance_o    <= cell_sum;
        last_in_row_o <= c_last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.op == OP_LOAD) begin
      tmpl_mem[item_i.index] <= item_i.sample;
    end
    if (adv) begin
      t_q <= tmpl_mem[j_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && c_valid_q) begin
      prev_mem[c_col_q] <= cell_sum;
    end
    if (adv) begin
      up_q <= prev_mem[j_q];
    end
  end

endmodule
`default_nettype wire

// ===== design/dtw_distance_matrix_top.sv =====
// Channel   Handshake                Payload
// in        in_valid_i / in_ready_o  command_i, template_index_i, sample_i
// out       out_valid_o / out_ready_i row_index_o, col_index_o, distance_o, last_in_row_o
// cfg       cfg_we_i                 cfg_data_i (template_length)
//
// A query item holds the back end while it is taken, while it walks one cell per cycle
// through the template and previous-row memories (unless the output stalls), and while
// stages B and C drain. Load and restart items are taken without leaving idle.
// Unknown commands are dropped at the front.
// Reset (rst_ni, async low) clears control state; template_length returns to 64.
// A two-item queue lets input be taken while the back end walks a row or the output stalls.
`default_nettype none
module dtw_distance_matrix_top
  import dtwdm_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [LEN_W-1:0]              cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [CMD_W-1:0]              command_i,
  input  wire logic [IDX_W-1:0]              template_index_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ROW_W-1:0]                   row_index_o,
  output logic [IDX_W-1:0]                   col_index_o,
  output logic [SUM_W-1:0]                   distance_o,
  output logic                               last_in_row_o
);

  logic  item_valid;
  logic  item_ready;
  item_t item;

  dtwdm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .template_index_i (template_index_i),
    .sample_i         (sample_i),
    .item_valid_o     (item_valid),
    .item_o           (item),
    .item_ready_i     (item_ready)
  );

  dtwdm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_ready_o  (item_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .row_index_o   (row_index_o),
    .col_index_o   (col_index_o),
    .distance_o    (distance_o),
    .last_in_row_o (last_in_row_o)
  );

endmodule
`default_nettype wire
